/* hdl/csvt_pkg.sv */
// shared types and constants of the csv byte tokenizer
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  // input item kinds
  localparam logic IN_TEXT = 1'b0;
  localparam logic IN_END  = 1'b1;

  // token kinds
  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_FIELD = 2'd1;
  localparam logic [1:0] K_ROW   = 2'd2;
  localparam logic [1:0] K_ERR   = 2'd3;

  // byte codes
  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [7:0] CH_BOM1  = 8'hBB;
  localparam logic [7:0] CH_BOM2  = 8'hBF;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // most tokens one request can cause, and default queue depth
  localparam int MAX_TOKENS  = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } tok_t;

  // all tokens of one request, in order, with their count
  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] toks;
    logic [1:0]            count;
  } bundle_t;

endpackage

`default_nettype wire

/* hdl/csvt_if.sv */
// valid/ready channel interfaces for text requests and tokens
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if ();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface csvt_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_kind, output out_byte, output last, input ready);
  modport sink (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* hdl/csvt_front.sv */
// front end: parser state, marker stripping and token bundle building
`timescale 1ns / 1ps
`default_nettype none

module csvt_front import csvt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  csvt_in_if.sink text,
  output logic    push_valid,
  input  logic    push_ready,
  output bundle_t push_data
);

  // byte order marker progress
  localparam logic [1:0] BOM_START = 2'd0;
  localparam logic [1:0] BOM_EF    = 2'd1;
  localparam logic [1:0] BOM_EFBB  = 2'd2;
  localparam logic [1:0] BOM_DONE  = 2'd3;

  logic       quoted, quoted_next;
  logic       quote_pending, quote_pending_next;
  logic       field_begun, field_begun_next;
  logic       row_begun, row_begun_next;
  logic [1:0] bom_stage, bom_stage_next;

  logic       accept;
  logic       replay;
  logic       handled;
  logic       do_plain;
  logic [1:0] n;
  bundle_t    bundle;

  assign text.ready = push_ready;
  assign accept     = text.valid && push_ready;

  // work out next state and the tokens of the current request
  always_comb begin
    quoted_next        = quoted;
    quote_pending_next = quote_pending;
    field_begun_next   = field_begun;
    row_begun_next     = row_begun;
    bom_stage_next     = bom_stage;
    bundle             = '0;
    n                  = 2'd0;
    replay             = 1'b0;
    handled            = 1'b0;
    do_plain           = 1'b0;

    // does this request break off or finish the marker
    if (text.kind == IN_END) begin
      replay = 1'b1;
    end else begin
      unique case (bom_stage)
        BOM_START: begin
          if (text.in_byte == CH_BOM0) begin
            bom_stage_next = BOM_EF;
            handled        = 1'b1;
          end else begin
            bom_stage_next = BOM_DONE;
          end
        end
        BOM_EF: begin
          if (text.in_byte == CH_BOM1) begin
            bom_stage_next = BOM_EFBB;
            handled        = 1'b1;
          end else begin
            replay = 1'b1;
          end
        end
        BOM_EFBB: begin
          if (text.in_byte == CH_BOM2) begin
            bom_stage_next = BOM_DONE;
            handled        = 1'b1;
          end else begin
            replay = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // held marker bytes come out as plain content
    if (replay && (bom_stage == BOM_EF || bom_stage == BOM_EFBB)) begin
      bundle.toks[n] = '{kind: K_BYTE, data: CH_BOM0};
      n = n + 2'd1;
      if (bom_stage == BOM_EFBB) begin
        bundle.toks[n] = '{kind: K_BYTE, data: CH_BOM1};
        n = n + 2'd1;
      end
      field_begun_next = 1'b1;
      row_begun_next   = 1'b1;
    end
    if (replay) begin
      bom_stage_next = BOM_DONE;
    end

    if (text.kind == IN_END) begin
      // close a pending quote, then flush the row or flag the open quote
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        quoted_next        = 1'b0;
      end
      if (quoted_next) begin
        bundle.toks[n] = '{kind: K_ERR, data: 8'd0};
        n = n + 2'd1;
      end else if (row_begun_next) begin
        bundle.toks[n] = '{kind: K_ROW, data: 8'd0};
        n = n + 2'd1;
      end
      quoted_next        = 1'b0;
      quote_pending_next = 1'b0;
      field_begun_next   = 1'b0;
      row_begun_next     = 1'b0;
      bom_stage_next     = BOM_START;
    end else if (!handled) begin
      // quoting decisions
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (text.in_byte == CH_QUOTE) begin
          bundle.toks[n] = '{kind: K_BYTE, data: CH_QUOTE};
          n = n + 2'd1;
        end else begin
          quoted_next = 1'b0;
          do_plain    = 1'b1;
        end
      end else if (quoted) begin
        if (text.in_byte == CH_QUOTE) begin
          quote_pending_next = 1'b1;
        end else begin
          bundle.toks[n] = '{kind: K_BYTE, data: text.in_byte};
          n = n + 2'd1;
        end
      end else begin
        do_plain = 1'b1;
      end

      // unquoted byte handling
      if (do_plain) begin
        if (text.in_byte == CH_QUOTE && !field_begun_next) begin
          quoted_next      = 1'b1;
          field_begun_next = 1'b1;
          row_begun_next   = 1'b1;
        end else if (text.in_byte == CH_COMMA) begin
          row_begun_next   = 1'b1;
          field_begun_next = 1'b0;
          bundle.toks[n] = '{kind: K_FIELD, data: 8'd0};
          n = n + 2'd1;
        end else if (text.in_byte == CH_CR) begin
          // carriage return dropped
        end else if (text.in_byte == CH_LF) begin
          if (row_begun_next) begin
            bundle.toks[n] = '{kind: K_ROW, data: 8'd0};
            n = n + 2'd1;
            field_begun_next = 1'b0;
            row_begun_next   = 1'b0;
          end
        end else begin
          bundle.toks[n] = '{kind: K_BYTE, data: text.in_byte};
          n = n + 2'd1;
          field_begun_next = 1'b1;
          row_begun_next   = 1'b1;
        end
      end
    end
    bundle.count = n;
  end

  assign push_valid = text.valid && (n != 2'd0);
  assign push_data  = bundle;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      quoted        <= 1'b0;
      quote_pending <= 1'b0;
      field_begun   <= 1'b0;
      row_begun     <= 1'b0;
      bom_stage     <= BOM_START;
    end else if (accept) begin
      quoted        <= quoted_next;
      quote_pending <= quote_pending_next;
      field_begun   <= field_begun_next;
      row_begun     <= row_begun_next;
      bom_stage     <= bom_stage_next;
    end
  end

  // a pending quote only exists inside quotes
  a_pending_quoted: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> quoted)
    else $error("quote pending outside a quoted field");

  // nothing has started while the marker is still undecided
  a_bom_clean: assert property (@(posedge clk) disable iff (rst)
    (bom_stage != BOM_DONE) |-> (!quoted && !row_begun && !field_begun))
    else $error("parser state set before start of input passed");

  // end of input returns the parser to its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && text.kind == IN_END) |=>
      (bom_stage == BOM_START && !quoted && !quote_pending && !row_begun && !field_begun))
    else $error("state not cleared after end of input");

endmodule

`default_nettype wire

/* hdl/csvt_queue.sv */
// small fifo of token bundles between front and back end
`timescale 1ns / 1ps
`default_nettype none

module csvt_queue import csvt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  bundle_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output bundle_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill level beyond depth");

endmodule

`default_nettype wire

/* hdl/csvt_back.sv */
// back end: plays out one token per cycle from each bundle while the receiver is ready
`timescale 1ns / 1ps
`default_nettype none

module csvt_back import csvt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  bundle_t      pop_data,
  csvt_out_if.source   tokens
);

  logic       have;
  bundle_t    cur;
  logic [1:0] idx;
  logic       last_tok;
  logic       fire;
  logic       pop;

  assign last_tok  = (idx == cur.count - 2'd1);
  assign fire      = have && tokens.ready;
  assign pop_ready = !have || (fire && last_tok);
  assign pop       = pop_valid && pop_ready;

  // output side
  assign tokens.valid    = have;
  assign tokens.out_kind = cur.toks[idx].kind;
  assign tokens.out_byte = cur.toks[idx].data;
  assign tokens.last     = last_tok;

  // token position within the held bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      have <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      if (last_tok) begin
        have <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  // held bundles are never empty
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    have |-> (cur.count != 2'd0 && idx < cur.count))
    else $error("token index outside held bundle");

  // a bundle keeps the output busy until its last token goes
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    (fire && !last_tok) |=> (tokens.valid && idx == $past(idx) + 2'd1))
    else $error("bundle dropped before its last token");

endmodule

`default_nettype wire

/* hdl/csv_byte_tokenizer.sv */
// top level of the streaming csv byte tokenizer
//
// Requests arrive on the text channel: kind 0 carries one text byte in
// in_byte, kind 1 marks end of input. Tokens leave on the tokens channel:
// field bytes, end of field, end of row and unterminated quote marks, with
// last set on the final token caused by one request. A request that causes
// no token (carriage return, skipped newline, marker byte) produces nothing.
// On its way out the first token of a request is registered, first by the
// front end into the bundle queue, then into the playout register of the
// back end.
// Throughput: one request per cycle while each request causes at most one
// token and the receiver is ready; a request with more than one token holds
// the output until its last token goes, since the back end plays out one
// token per cycle. The bundle queue (QUEUE_DEPTH entries) plus the playout
// register let the front end keep accepting while tokens wait.
// When the receiver stalls, tokens hold and the queue fills; text.ready
// drops once the queue is full. Reset clears the parser state and empties
// the queue, so marker detection restarts at the first byte.
`timescale 1ns / 1ps
`default_nettype none

module csv_byte_tokenizer import csvt_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  csvt_in_if.sink    text,
  csvt_out_if.source tokens
);

  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  bundle_t pop_data;

  // parsing and token building
  csvt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  csvt_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  // token playout
  csvt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .tokens    (tokens)
  );

endmodule

`default_nettype wire
